// ===== rtl/core/ktl_pkg.sv =====
package ktl_pkg;

  localparam int MaxFrames = 64;
  localparam int IdxW      = $clog2(MaxFrames);
  localparam int CntW      = $clog2(MaxFrames + 1);
  localparam int NumCh     = 5;
  localparam int ValW      = 16;
  localparam int ProdW     = ValW + 32;
  localparam int StepW     = $clog2(ProdW);

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StLate = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;

  typedef enum logic [1:0] {
    OpClear,
    OpAppend,
    OpQuery,
    OpNone
  } op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] stamp_ms;
    logic [4:0]  given_mask;
    logic [15:0] power_value;
    logic [11:0] cadence_value;
    logic [11:0] heart_value;
    logic [11:0] speed_value;
    logic [11:0] resist_value;
    logic [31:0] quiet_ms;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  known_mask;
    logic [15:0] power_out;
    logic [11:0] cadence_out;
    logic [11:0] heart_out;
    logic [11:0] speed_out;
    logic [11:0] resist_out;
    logic        silent_flag;
    logic [32:0] ride_length_ms;
  } out_beat_t;

  typedef struct packed {
    op_e      op;
    in_beat_t beat;
  } job_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [31:0] quiet_ms;
    logic [4:0]  mask;
    logic [15:0] power;
    logic [11:0] cadence;
    logic [11:0] heart;
    logic [11:0] speed;
    logic [11:0] resist;
  } entry_t;

  // Pick one channel of a stored keyframe, zero-extended to lane width.
  function automatic logic [ValW-1:0] ch_val(entry_t e, int ch);
    logic [ValW-1:0] v;
    case (ch)
      0:       v = e.power;
      1:       v = {4'd0, e.cadence};
      2:       v = {4'd0, e.heart};
      3:       v = {4'd0, e.speed};
      default: v = {4'd0, e.resist};
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ktl_queue.sv =====
module ktl_queue
  import ktl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic pop_valid_o,
  output job_t pop_job_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o      = (fill_q == 2'd2);
  assign pop_valid_o = (fill_q != 2'd0);
  assign pop_job_o   = slot_q[rd_ptr_q];

  // Advance pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (pop_i && !push_i) fill_q <= fill_q - 2'd1;
    end
  end

  // Store the pushed beat.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_job_i;
  end

endmodule

// ===== rtl/core/ktl_front.sv =====
module ktl_front
  import ktl_pkg::*;
(
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_beat_t in_beat_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output job_t     push_job_o
);

  // Hold the sender while the queue is full.
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Classify the command.
  always_comb begin
    push_job_o.beat = in_beat_i;
    case (in_beat_i.command)
      CmdClear:  push_job_o.op = OpClear;
      CmdAppend: push_job_o.op = OpAppend;
      CmdQuery:  push_job_o.op = OpQuery;
      default:   push_job_o.op = OpNone;
    endcase
  end

endmodule

// ===== rtl/core/ktl_back.sv =====
module ktl_back
  import ktl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SDrain = 3'd2;
  localparam logic [2:0] SMul   = 3'd3;
  localparam logic [2:0] SDiv   = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]      state_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] idx_q;
  logic [31:0]     last_time_q;
  logic [32:0]     ride_q, ride_d;
  logic [31:0]     t_q;
  logic            rd_vld_q;
  entry_t          rd_q;
  entry_t          mem [MaxFrames];
  logic [StepW-1:0] step_q;
  logic            silent_q;

  logic [ValW-1:0]  lo_val_q  [NumCh];
  logic [ValW-1:0]  hi_val_q  [NumCh];
  logic [31:0]      lo_time_q [NumCh];
  logic [31:0]      hi_time_q [NumCh];
  logic             have_lo_q [NumCh];
  logic             have_hi_q [NumCh];
  logic [ProdW-1:0] num_q     [NumCh];
  logic [31:0]      rem_q     [NumCh];

  logic      out_free, ld, append_ok, rd_silent;
  out_beat_t out_q, out_d;
  entry_t    wr_entry;
  logic [1:0] app_status;

  assign out_free    = !out_valid_o || !out_stall_i;
  assign pop_o       = job_valid_i && (state_q == SIdle) && ((job_i.op == OpQuery) || out_free);
  assign out_beat_o  = out_q;

  // Check an append against the last keyframe and the table size.
  always_comb begin
    app_status = StOk;
    if (cnt_q != '0 && job_i.beat.stamp_ms <= last_time_q) app_status = StLate;
    else if (cnt_q >= CntW'(MaxFrames))                  app_status = StFull;
  end
  assign append_ok = pop_o && (job_i.op == OpAppend) && (app_status == StOk);

  assign wr_entry.time_ms  = job_i.beat.stamp_ms;
  assign wr_entry.quiet_ms = job_i.beat.quiet_ms;
  assign wr_entry.mask     = job_i.beat.given_mask;
  assign wr_entry.power    = job_i.beat.power_value;
  assign wr_entry.cadence  = job_i.beat.cadence_value;
  assign wr_entry.heart    = job_i.beat.heart_value;
  assign wr_entry.speed    = job_i.beat.speed_value;
  assign wr_entry.resist   = job_i.beat.resist_value;

  // Ride length after this beat.
  always_comb begin
    ride_d = ride_q;
    if (pop_o && job_i.op == OpClear) ride_d = '0;
    else if (append_ok) ride_d = {1'b0, job_i.beat.stamp_ms} + {1'b0, job_i.beat.quiet_ms};
  end

  // Keyframe memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (append_ok) mem[cnt_q[IdxW-1:0]] <= wr_entry;
    rd_q <= mem[idx_q];
  end

  assign rd_silent = (rd_q.quiet_ms != 32'd0) && (t_q >= rd_q.time_ms) &&
                     ({1'b0, t_q} < ({1'b0, rd_q.time_ms} + {1'b0, rd_q.quiet_ms}));

  // Control: sequence scan, multiply and divide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      last_time_q <= '0;
      ride_q      <= '0;
      rd_vld_q    <= 1'b0;
      step_q      <= '0;
    end else begin
      rd_vld_q <= (state_q == SScan);
      ride_q   <= ride_d;
      case (state_q)
        SIdle: begin
          if (pop_o) begin
            if (job_i.op == OpClear) cnt_q <= '0;
            if (append_ok) begin
              cnt_q       <= cnt_q + CntW'(1);
              last_time_q <= job_i.beat.stamp_ms;
            end
            if (job_i.op == OpQuery) begin
              idx_q   <= '0;
              state_q <= (cnt_q == '0) ? SMul : SScan;
            end
          end
        end
        SScan: begin
          idx_q <= idx_q + IdxW'(1);
          if ({1'b0, idx_q} == cnt_q - CntW'(1)) state_q <= SDrain;
        end
        SDrain: state_q <= SMul;
        SMul: begin
          step_q  <= '0;
          state_q <= SDiv;
        end
        SDiv: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(ProdW - 1)) state_q <= SDone;
        end
        SDone: begin
          if (out_free) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Lanes: bracket keyframes per channel, then divide one bit a cycle.
  always_ff @(posedge clk_i) begin
    if (pop_o && job_i.op == OpQuery) begin
      t_q      <= job_i.beat.stamp_ms;
      silent_q <= 1'b0;
      for (int c = 0; c < NumCh; c++) begin
        have_lo_q[c] <= 1'b0;
        have_hi_q[c] <= 1'b0;
      end
    end
    if (rd_vld_q) begin
      if (rd_silent) silent_q <= 1'b1;
      for (int c = 0; c < NumCh; c++) begin
        if (rd_q.mask[c]) begin
          if (rd_q.time_ms <= t_q) begin
            lo_val_q[c]  <= ch_val(rd_q, c);
            lo_time_q[c] <= rd_q.time_ms;
            have_lo_q[c] <= 1'b1;
          end else if (!have_hi_q[c]) begin
            hi_val_q[c]  <= ch_val(rd_q, c);
            hi_time_q[c] <= rd_q.time_ms;
            have_hi_q[c] <= 1'b1;
          end
        end
      end
    end
    if (state_q == SMul) begin
      for (int c = 0; c < NumCh; c++) begin
        num_q[c] <= ProdW'((hi_val_q[c] >= lo_val_q[c]) ? (hi_val_q[c] - lo_val_q[c])
                                                        : (lo_val_q[c] - hi_val_q[c]))
                    * ProdW'(t_q - lo_time_q[c]);
        rem_q[c] <= '0;
      end
    end
    if (state_q == SDiv) begin
      for (int c = 0; c < NumCh; c++) begin
        if ({rem_q[c], num_q[c][ProdW-1]} >= {1'b0, hi_time_q[c] - lo_time_q[c]}) begin
          rem_q[c] <= 32'({rem_q[c], num_q[c][ProdW-1]} -
                          {1'b0, hi_time_q[c] - lo_time_q[c]});
          num_q[c] <= {num_q[c][ProdW-2:0], 1'b1};
        end else begin
          rem_q[c] <= {rem_q[c][30:0], num_q[c][ProdW-1]};
          num_q[c] <= {num_q[c][ProdW-2:0], 1'b0};
        end
      end
    end
  end

  // Build the result beat.
  always_comb begin
    logic [ValW-1:0] v [NumCh];
    logic [4:0]      known;
    ld    = 1'b0;
    out_d = '0;
    known = '0;
    for (int c = 0; c < NumCh; c++) begin
      v[c] = '0;
      if (have_lo_q[c]) begin
        known[c] = 1'b1;
        if (!have_hi_q[c])                   v[c] = lo_val_q[c];
        else if (hi_val_q[c] >= lo_val_q[c]) v[c] = lo_val_q[c] + num_q[c][ValW-1:0];
        else                                 v[c] = lo_val_q[c] - num_q[c][ValW-1:0];
      end
    end
    out_d.ride_length_ms = ride_d;
    if (state_q == SIdle && pop_o && job_i.op != OpQuery) begin
      ld = 1'b1;
      if (job_i.op == OpAppend) out_d.status = app_status;
    end else if (state_q == SDone && out_free) begin
      ld = 1'b1;
      if (silent_q) begin
        out_d.silent_flag = 1'b1;
      end else begin
        out_d.known_mask  = known;
        out_d.power_out   = v[0];
        out_d.cadence_out = v[1][11:0];
        out_d.heart_out   = v[2][11:0];
        out_d.speed_out   = v[3][11:0];
        out_d.resist_out  = v[4][11:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ld) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) out_q <= out_d;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxFrames)) else $error("frame count beyond table size");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld && out_d.status == StFull |-> cnt_q == CntW'(MaxFrames))
    else $error("full status with room left");
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SScan |-> {1'b0, idx_q} < cnt_q) else $error("scan past fill");
  a_silent_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld && out_d.silent_flag |-> out_d.known_mask == 5'd0)
    else $error("silent answer carries channels");
`endif

endmodule

// ===== rtl/core/keyframe_timeline_interpolator_core.sv =====
// Keyframe timeline interpolator.
// Input channel in_valid_i/in_stall_o/in_beat_i carries commands: clear the
// table, append a keyframe, or query all channels at a time stamp. Output
// channel out_valid_o/out_stall_i/out_beat_o returns one beat per command.
// A two-entry queue sits between the command front end and the execution
// back end, so the sender keeps going while the back end works.
// Clear and append complete in the back end in the cycle they are popped from
// the queue, and their result is loaded into the output register. A query reads
// the keyframe memory one entry a cycle, then runs a 16x32 multiply and a
// 48-bit bit-serial divide in five parallel lanes.
// Reset empties the table and the queue and clears the output valid; the
// memory contents need no clearing. While the receiver stalls, the finished
// beat holds in the output register, the back end stops before loading the
// next result, and the input stalls once the queue fills.
module keyframe_timeline_interpolator_core
  import ktl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic push, full, pop, job_valid;
  job_t push_job, pop_job;

  ktl_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_beat_i    (in_beat_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  ktl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (job_valid),
    .pop_job_o   (pop_job)
  );

  ktl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
